### rtl/mats_pkg.sv
// Shared types and constants for the moving average threshold slicer.
// No dependencies; imported by mats_ring and the top level.
`default_nettype none

package mats_pkg;

  // pulse length register: fixed width and reset value
  localparam int unsigned SPP_W     = 5;
  localparam int unsigned SPP_RESET = 8;

  // Per-cycle control from the pipeline handshake to the ring datapath
  typedef struct packed {
    logic accept;  // new request enters stage A, ring read issued
    logic retire;  // stage A item moves on, ring write and sum update
    logic clear;   // register write: empty the window
  } ring_ctl_t;

endpackage

`default_nettype wire

### rtl/moving_average_threshold_slicer.sv
// Top level of the moving average threshold slicer: handshake pipeline,
// window length register, product and compare. Depends on mats_pkg, mats_ring.
//
//   channel   dir  handshake                 payload
//   config    in   cfg_we_i                  pulse_len_i[4:0]
//   input     in   in_valid_i / in_stall_o   sample_i[SAMPLE_WIDTH-1:0]
//   output    out  out_valid_o / out_stall_i decision_o
//
// One request per clock sustained while out_stall_i is low. Three register
// stages (A: ring read and product, B: sum update, C: compare); out_valid_o
// rises when the item has passed A and B into C, where it is held until taken.
// The ring RAM has one read and one write port, used once per request each.
// Reset or a register write empties the window; no clearing pass is needed.
// Output stall holds the result register; the two stages behind it still
// fill, so input stall rises only when all three stages are occupied.
`default_nettype none

module moving_average_threshold_slicer #(
  parameter int unsigned PULSES_IN_WINDOW      = 32,
  parameter int unsigned MAX_SAMPLES_PER_PULSE = 16,
  parameter int unsigned SAMPLE_WIDTH          = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mats_pkg::SPP_W-1:0]     pulse_len_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                decision_o
);

  import mats_pkg::*;

  localparam int unsigned RING_DEPTH = PULSES_IN_WINDOW * MAX_SAMPLES_PER_PULSE;
  localparam int unsigned POS_BITS   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned N_W        = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W      = POS_BITS + SAMPLE_WIDTH;
  localparam int unsigned PROD_W     = SAMPLE_WIDTH + N_W + 1;
  localparam int unsigned CMP_W      = (PROD_W > SUM_W) ? PROD_W : SUM_W + 1;
  localparam int unsigned SPP_RST_EFF =
    (SPP_RESET > MAX_SAMPLES_PER_PULSE) ? MAX_SAMPLES_PER_PULSE : SPP_RESET;
  localparam int unsigned N_RESET    = SPP_RST_EFF * PULSES_IN_WINDOW;

  // window length register
  logic [N_W-1:0]  n_q, n_d;
  int unsigned     spp_eff;

  always_comb begin
    if (pulse_len_i == '0) begin
      spp_eff = 1;
    end else if (32'(pulse_len_i) > MAX_SAMPLES_PER_PULSE) begin
      spp_eff = MAX_SAMPLES_PER_PULSE;
    end else begin
      spp_eff = 32'(pulse_len_i);
    end
    n_d = cfg_we_i ? N_W'(spp_eff * PULSES_IN_WINDOW) : n_q;
  end

  // pipeline handshake
  logic a_valid_q, b_valid_q, c_valid_q;
  logic a_ready, b_ready, c_ready;
  logic a_move, b_move, accept;

  assign c_ready = !c_valid_q || !out_stall_i;
  assign b_ready = !b_valid_q || c_ready;
  assign a_ready = !a_valid_q || b_ready;
  assign b_move  = b_valid_q && c_ready;
  assign a_move  = a_valid_q && b_ready;
  assign accept  = in_valid_i && a_ready;

  assign in_stall_o  = !a_ready;
  assign out_valid_o = c_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      n_q       <= N_W'(N_RESET);
    end else begin
      a_valid_q <= a_ready ? in_valid_i : 1'b1;
      b_valid_q <= b_ready ? a_valid_q : 1'b1;
      c_valid_q <= c_ready ? b_valid_q : 1'b1;
      n_q       <= n_d;
    end
  end

  // magnitude and sample * N
  logic        [SAMPLE_WIDTH-1:0] mag;
  logic signed [PROD_W-1:0]       prod_d;

  assign mag    = sample_i[SAMPLE_WIDTH-1] ? ($unsigned(~sample_i) + SAMPLE_WIDTH'(1))
                                           : $unsigned(sample_i);
  assign prod_d = PROD_W'(sample_i) * PROD_W'($signed({1'b0, n_q}));

  ring_ctl_t        ring_ctl;
  logic [SUM_W-1:0] new_sum;

  assign ring_ctl.accept = accept;
  assign ring_ctl.retire = a_move;
  assign ring_ctl.clear  = cfg_we_i;

  mats_ring #(
    .RING_DEPTH (RING_DEPTH),
    .MAG_W      (SAMPLE_WIDTH),
    .N_W        (N_W),
    .SUM_W      (SUM_W)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ring_ctl),
    .n_i       (n_q),
    .mag_i     (mag),
    .new_sum_o (new_sum)
  );

  // stage payloads
  logic signed [PROD_W-1:0] a_prod_q, b_prod_q;
  logic [SUM_W-1:0]         b_sum_q;
  logic                     decision_q;
  logic                     above_mean;

  assign above_mean = CMP_W'(b_prod_q) > CMP_W'($signed({1'b0, b_sum_q}));

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_prod_q <= prod_d;
    end
    if (a_move) begin
      b_prod_q <= a_prod_q;
      b_sum_q  <= new_sum;
    end
    if (b_move) begin
      decision_q <= above_mean;
    end
  end

  assign decision_o = decision_q;

  a_result_from_stage_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(c_valid_q) |-> $past(b_valid_q))
    else $error("result appeared without an item in stage B");

  a_empty_front_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !a_valid_q |-> !in_stall_o)
    else $error("input stalled with stage A empty");

  a_held_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !b_ready) |=> $stable(a_prod_q))
    else $error("stage A product changed while held");

endmodule

`default_nettype wire

### rtl/mats_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module mats_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/mats_ring.sv
// Magnitude ring and running sum: ring position, fill flag, RAM and adder.
// Depends on mats_pkg and mats_ram.
`default_nettype none

module mats_ring #(
  parameter int unsigned RING_DEPTH = 512,
  parameter int unsigned MAG_W      = 16,
  parameter int unsigned N_W        = 10,
  parameter int unsigned SUM_W      = 25,
  localparam int unsigned POS_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mats_pkg::ring_ctl_t ctl_i,
  input  wire logic [N_W-1:0]      n_i,
  input  wire logic [MAG_W-1:0]    mag_i,
  output logic      [SUM_W-1:0]    new_sum_o
);

  import mats_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic             full_q, full_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [POS_W-1:0] last_pos;

  // stage A payload
  logic [POS_W-1:0] a_pos_q;
  logic             a_full_q;
  logic [MAG_W-1:0] a_mag_q;
  logic             fwd_q;
  logic [MAG_W-1:0] fwd_mag_q;

  logic [MAG_W-1:0] rdata;
  logic [MAG_W-1:0] old_mag;

  assign last_pos = POS_W'(n_i - N_W'(1));

  // Entries are filled in order from zero, so until the first wrap the fill
  // flag is clear and the old magnitude at the ring position is taken as zero.
  always_comb begin
    pos_d  = pos_q;
    full_d = full_q;
    if (ctl_i.clear) begin
      pos_d  = '0;
      full_d = 1'b0;
    end else if (ctl_i.accept) begin
      if (pos_q == last_pos) begin
        pos_d  = '0;
        full_d = 1'b1;
      end else begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      a_pos_q   <= pos_q;
      a_full_q  <= full_q;
      a_mag_q   <= mag_i;
      fwd_q     <= ctl_i.retire && (pos_q == a_pos_q);
      fwd_mag_q <= a_mag_q;
    end
  end

  // Read at accept, write at retire. Only a one-entry window reads the entry
  // that stage A writes in the same cycle; that value is forwarded instead.
  mats_ram #(
    .WIDTH (MAG_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.retire),
    .waddr_i (a_pos_q),
    .wdata_i (a_mag_q),
    .re_i    (ctl_i.accept),
    .raddr_i (pos_q),
    .rdata_o (rdata)
  );

  assign old_mag = !a_full_q ? '0 : (fwd_q ? fwd_mag_q : rdata);

  always_comb begin
    sum_d = sum_q;
    if (ctl_i.clear) begin
      sum_d = '0;
    end else if (ctl_i.retire) begin
      sum_d = sum_q - SUM_W'(old_mag) + SUM_W'(a_mag_q);
    end
  end

  assign new_sum_o = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      full_q <= 1'b0;
      sum_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      full_q <= full_d;
      sum_q  <= sum_d;
    end
  end

  a_pos_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) < 32'(n_i))
    else $error("ring position outside the window");

  a_rw_overlap_short_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.accept && ctl_i.retire && (pos_q == a_pos_q)) |-> (n_i == N_W'(1)))
    else $error("ring read and write hit the same entry");

  a_full_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_q) |-> (pos_q == '0))
    else $error("ring marked full without a wrap");

endmodule

`default_nettype wire
